### rtl/npci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npci_pkg
// Shared types and constants for the nearest palette color index core:
// palette rom, channel and distance widths.
// ----------------------------------------------------------------------------
package npci_pkg;

    // palette geometry
    localparam int NUM_ENTRIES = 16;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int CHAN_W      = 8;
    localparam int RGB_W       = 3 * CHAN_W;
    localparam int SQ_W        = 2 * CHAN_W;
    // three squares of 255 fit in 18 bits
    localparam int DIST_W      = SQ_W + 2;

    typedef logic [IDX_W-1:0]  t_index;
    typedef logic [RGB_W-1:0]  t_rgb;
    typedef logic [DIST_W-1:0] t_dist;

    // palette rom, 0xRRGGBB per index
    localparam t_rgb PALETTE [NUM_ENTRIES] = '{
        24'h000000, 24'h8b0000, 24'h006400, 24'hb5b820,
        24'h00008b, 24'h8b008b, 24'h008b8b, 24'hcccccc,
        24'h444444, 24'hff0000, 24'h00ff00, 24'hffff00,
        24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff
    };

endpackage : npci_pkg
`default_nettype wire

### rtl/npci_dist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npci_dist
// Squared euclidean distance between a color and one palette entry:
// sum of the squared red, green and blue differences.
// ----------------------------------------------------------------------------
module npci_dist (
    input  wire npci_pkg::t_rgb  i_rgb,
    input  wire npci_pkg::t_rgb  i_ref,
    output npci_pkg::t_dist      o_dist
);
    import npci_pkg::*;

    logic [CHAN_W-1:0] a_chan [3];
    logic [CHAN_W-1:0] b_chan [3];
    logic [CHAN_W-1:0] diff   [3];
    logic [SQ_W-1:0]   sq     [3];

    // per channel absolute difference and square
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            a_chan[c] = i_rgb[c*CHAN_W +: CHAN_W];
            b_chan[c] = i_ref[c*CHAN_W +: CHAN_W];
            diff[c]   = (a_chan[c] > b_chan[c]) ? (a_chan[c] - b_chan[c])
                                                : (b_chan[c] - a_chan[c]);
            sq[c]     = SQ_W'(diff[c]) * SQ_W'(diff[c]);
        end
    end

    // sum of the three squares
    assign o_dist = t_dist'(sq[0]) + t_dist'(sq[1]) + t_dist'(sq[2]);

endmodule : npci_dist
`default_nettype wire

### rtl/npci_argmin.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npci_argmin
// Compare tree over the palette distances, gives the index of the smallest.
// On a tie the lower index wins.
// ----------------------------------------------------------------------------
module npci_argmin (
    input  wire npci_pkg::t_dist  i_dist [npci_pkg::NUM_ENTRIES],
    output npci_pkg::t_index      o_index
);
    import npci_pkg::*;

    t_dist  lvl_d [IDX_W+1][NUM_ENTRIES];
    t_index lvl_i [IDX_W+1][NUM_ENTRIES];

    // pairwise tree, the right side wins only when strictly smaller
    always_comb begin
        for (int l = 0; l <= IDX_W; l++) begin
            for (int k = 0; k < NUM_ENTRIES; k++) begin
                lvl_d[l][k] = '0;
                lvl_i[l][k] = '0;
            end
        end
        for (int k = 0; k < NUM_ENTRIES; k++) begin
            lvl_d[0][k] = i_dist[k];
            lvl_i[0][k] = t_index'(k);
        end
        for (int l = 0; l < IDX_W; l++) begin
            for (int k = 0; k < (NUM_ENTRIES >> (l + 1)); k++) begin
                if (lvl_d[l][2*k+1] < lvl_d[l][2*k]) begin
                    lvl_d[l+1][k] = lvl_d[l][2*k+1];
                    lvl_i[l+1][k] = lvl_i[l][2*k+1];
                end else begin
                    lvl_d[l+1][k] = lvl_d[l][2*k];
                    lvl_i[l+1][k] = lvl_i[l][2*k];
                end
            end
        end
    end

    assign o_index = lvl_i[IDX_W][0];

endmodule : npci_argmin
`default_nettype wire

### rtl/nearest_palette_color_index_core.sv
// An accepted color word passes the input, distance and result registers in order.
// Throughput: one word per cycle while the output is not backpressured.
// The distance stage holds 16 parallel distance units, one per palette entry.
// Backpressure stalls each stage only while its downstream register is full.
// Reset (synchronous, active low) clears the stage valid flags; no other state.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_index_core
// Maps an rgba color word to the index of the nearest entry of a fixed
// 16-color palette by squared euclidean rgb distance; alpha is ignored.
// ----------------------------------------------------------------------------
module nearest_palette_color_index_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  [31:0]              i_color_rgba,
    output logic                     o_valid,
    input  wire                      i_ready,
    output npci_pkg::t_index         o_palette_index
);
    import npci_pkg::*;

    // stage registers
    logic   r_a_valid, r_b_valid, r_c_valid;
    t_rgb   r_rgb;
    t_dist  r_dist [NUM_ENTRIES];
    t_index r_index;

    logic   a_ready, b_ready, c_ready;
    t_dist  n_dist [NUM_ENTRIES];
    t_index n_index;

    // ready chain, a stage takes a word when it is empty or drains this cycle
    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // input stage: keep rgb, drop alpha
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_rgb <= i_color_rgba[31 -: RGB_W];
        end
    end

    // distance units, one per palette entry
    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_dist
        npci_dist u_dist (
            .i_rgb  (r_rgb),
            .i_ref  (PALETTE[g]),
            .o_dist (n_dist[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_dist <= n_dist;
        end
    end

    // minimum search over registered distances
    npci_argmin u_argmin (
        .i_dist  (r_dist),
        .o_index (n_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready && r_b_valid) begin
            r_index <= n_index;
        end
    end

    // result word
    assign o_valid         = r_c_valid;
    assign o_palette_index = r_index;

endmodule : nearest_palette_color_index_core
`default_nettype wire
